// File: hdl/b64e_pkg.sv
// Package for the base64 line-wrapping encoder.
// Holds the command record passed from front to back, queue sizing and the alphabet lookup.
// No dependencies.
package b64e_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
  localparam logic [7:0] NEWLINE_CHAR      = 8'h0A;
  localparam logic [7:0] PAD_CHAR          = 8'h3D;
  localparam logic [7:0] GROUP_CHARS       = 8'd4;

  // Output step codes within one command.
  localparam logic [2:0] STEP_C0 = 3'd0;
  localparam logic [2:0] STEP_C1 = 3'd1;
  localparam logic [2:0] STEP_C2 = 3'd2;
  localparam logic [2:0] STEP_C3 = 3'd3;
  localparam logic [2:0] STEP_NL = 3'd4;

  typedef struct packed {
    logic        has_group;
    logic [23:0] bits;
    logic [1:0]  nvalid;    // real bytes in the group, 1..3
    logic        nl;        // newline after the group (or alone)
  } cmd_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] i8;
    i8 = {2'b00, idx};
    if (idx < 6'd26) begin
      b64_char = 8'h41 + i8;
    end else if (idx < 6'd52) begin
      b64_char = 8'h61 + (i8 - 8'd26);
    end else if (idx < 6'd62) begin
      b64_char = 8'h30 + (i8 - 8'd52);
    end else if (idx == 6'd62) begin
      b64_char = 8'h2B;
    end else begin
      b64_char = 8'h2F;
    end
  endfunction

endpackage

// File: hdl/b64e_front.sv
// Front end: accepts input requests, gathers bytes into groups, tracks the line column.
// Pushes one command per request that yields output. Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] data_byte,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [7:0] line_length;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic [1:0] pcount;
  logic [7:0] line_count;

  logic       accept;
  logic [8:0] sum;
  logic       wrap;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign sum      = {1'b0, line_count} + {1'b0, GROUP_CHARS};
  assign wrap     = sum >= {1'b0, line_length};

  always_comb begin
    push_cmd           = '0;
    push_cmd.has_group = 1'b0;
    push               = 1'b0;
    if (!kind) begin
      push_cmd.has_group = 1'b1;
      push_cmd.bits      = {pend0, pend1, data_byte};
      push_cmd.nvalid    = 2'd3;
      push_cmd.nl        = wrap;
      push               = accept && (pcount >= 2'd2);
    end else begin
      // finish: a flushed group is always followed by a newline
      if (pcount == 2'd1) begin
        push_cmd.has_group = 1'b1;
        push_cmd.bits      = {pend0, 16'h0000};
        push_cmd.nvalid    = 2'd1;
        push_cmd.nl        = 1'b1;
      end else if (pcount >= 2'd2) begin
        push_cmd.has_group = 1'b1;
        push_cmd.bits      = {pend0, pend1, 8'h00};
        push_cmd.nvalid    = 2'd2;
        push_cmd.nl        = 1'b1;
      end else begin
        push_cmd.nl = line_count != 8'd0;
      end
      push = accept && (push_cmd.has_group || push_cmd.nl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LINE_LENGTH_RESET;
      pcount      <= 2'd0;
      line_count  <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        line_length <= cfg_wr_data;
      end
      if (accept) begin
        if (kind) begin
          pcount     <= 2'd0;
          line_count <= 8'd0;
        end else if (pcount >= 2'd2) begin
          pcount     <= 2'd0;
          line_count <= wrap ? 8'd0 : sum[7:0];
        end else begin
          pcount <= pcount + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !kind && pcount == 2'd0) begin
      pend0 <= data_byte;
    end
    if (accept && !kind && pcount == 2'd1) begin
      pend1 <= data_byte;
    end
  end

endmodule

// File: hdl/b64e_queue.sv
// Short command queue between front and back ends.
// Depends on b64e_pkg for the command type and depth.
module b64e_queue import b64e_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = count == '0;
  assign full  = count == QCNT_W'(QDEPTH);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hdl/b64e_back.sv
// Back end: walks each command one character per cycle, unless stalled, into a
// registered output stage. Depends on b64e_pkg for the command type and alphabet.
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last
);

  logic       busy;
  cmd_t       cmd;
  logic [2:0] step;

  logic       advance;
  logic       emit;
  cmd_t       sel_cmd;
  logic [2:0] sel_step;
  logic [7:0] char_next;
  logic       last_next;

  assign advance  = !out_valid || !out_stall;
  assign emit     = advance && (busy || !empty);
  assign pop      = advance && !busy && !empty;
  assign sel_cmd  = busy ? cmd : head;
  assign sel_step = busy ? step : (head.has_group ? STEP_C0 : STEP_NL);

  always_comb begin
    case (sel_step)
      STEP_C0: char_next = b64_char(sel_cmd.bits[23:18]);
      STEP_C1: char_next = b64_char(sel_cmd.bits[17:12]);
      STEP_C2: char_next = (sel_cmd.nvalid > 2'd1) ? b64_char(sel_cmd.bits[11:6]) : PAD_CHAR;
      STEP_C3: char_next = (sel_cmd.nvalid > 2'd2) ? b64_char(sel_cmd.bits[5:0]) : PAD_CHAR;
      default: char_next = NEWLINE_CHAR;
    endcase
    last_next = (sel_step == STEP_NL) || (sel_step == STEP_C3 && !sel_cmd.nl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
      if (emit) begin
        busy <= !last_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= char_next;
      last     <= last_next;
      cmd      <= sel_cmd;
      step     <= sel_step + 3'd1;
    end
  end

endmodule

// File: hdl/base64_stream_encoder_line_wrap_top.sv
// Top level of the streaming base64 encoder with line wrapping.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Input channel (in_valid/in_stall, kind, data_byte): kind 0 carries a raw byte,
// kind 1 finishes the stream, flushing a partial group with '=' padding and
// ending an open line with a newline.
// Output channel (out_valid/out_stall, out_char, last): one ASCII character per
// transfer; last marks the final character caused by one input request.
// Configuration: cfg_wr_en/cfg_wr_data write line_length (reset 76); write it
// only while the block is idle.
// The first character of a request passes through the command queue and is then
// registered in the output stage. The output stage gives one character per
// cycle while the receiver does not stall, four for a completed group or five with
// a newline; the front takes a request every cycle while the two-entry command
// queue has room, and requests that yield nothing never wait on the queue beyond that.
// Reset (rst, synchronous): discards the held bytes, clears the line column, queue and
// output stage, and restores line_length to 76.
// When the receiver stalls, the output character holds; the queue fills and
// then in_stall rises until the back end drains an entry.
module base64_stream_encoder_line_wrap_top import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic empty;
  logic full;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full     (full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  b64e_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char (out_char),
    .last     (last)
  );

endmodule

// File: hdl/b64e_checker.sv
// Port-level checker for the base64 encoder top level, with its bind statement.
// Depends only on the top level's ports.
module b64e_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       last
);

  // hold a stalled character
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
    else $error("output changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // a newline always closes the request's output
  a_nl_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == 8'h0A |-> last)
    else $error("newline not marked last");

  // padding only occurs on a finish, which always ends with a newline
  a_pad_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == 8'h3D |-> !last)
    else $error("padding marked last");

endmodule

bind base64_stream_encoder_line_wrap_top b64e_checker u_b64e_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_char (out_char),
  .last     (last)
);
